[design/hcbd_pkg.sv]
package hcbd_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam int NAME_LEN = 17;
    localparam int WORD_LEN = 7;

    // lower-case forms, matching is case-insensitive
    localparam logic [7:0] NAME_TEXT [NAME_LEN] = '{
        "t", "r", "a", "n", "s", "f", "e", "r", "-",
        "e", "n", "c", "o", "d", "i", "n", "g"
    };

    localparam logic [7:0] WORD_TEXT [WORD_LEN] = '{
        "c", "h", "u", "n", "k", "e", "d"
    };

    typedef struct packed {
        logic [7:0] data;
        logic       keep;
        logic       last;
    } result_t;

endpackage

[design/http_chunked_body_decoder_core.sv]
// http chunked body decoder
//
// input channel: in_valid / in_ready carry one response byte per item
// (in_byte) with in_last on the final byte of a response.
// output channel: out_valid / out_ready carry one item per input item:
// out_byte echoes the byte, keep marks bytes of the decoded stream,
// out_last copies in_last.
// header bytes through the first blank line are always kept; when the
// transfer-encoding line names chunked, size lines, chunk trailers and
// bytes after the final chunk get keep low.
// the result is registered: out_valid rises in the cycle after accept.
// throughput: one item per cycle while out_ready takes each result, set
// by the single decode stage in front of the output register.
// reset clears the decode state and empties the output register.
// when the receiver stalls with a result held, in_ready drops in the
// same cycle and rises again as soon as that result is taken.
// decode state returns to its reset value after an item with in_last.
module http_chunked_body_decoder_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       keep,
    output logic       out_last
);

    logic    step;
    result_t result;

    assign step = in_valid && in_ready;

    hcbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (in_byte),
        .in_last (in_last),
        .result  (result)
    );

    hcbd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .result    (result),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .keep      (keep),
        .out_last  (out_last)
    );

endmodule

[design/hcbd_parser.sv]
module hcbd_parser
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output result_t    result
);

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_PASS      = 3'd1,
        PH_DIGITS    = 3'd2,
        PH_SIZE_SKIP = 3'd3,
        PH_DATA      = 3'd4,
        PH_TRAILER   = 3'd5,
        PH_DONE      = 3'd6
    } phase_t;

    localparam logic [4:0] NAME_END = 5'(NAME_LEN);
    localparam logic [2:0] WORD_END = 3'(WORD_LEN);
    localparam logic [SIZE_BITS-1:0] COUNT_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             blank_reg, blank_next;
    logic [4:0]             name_reg, name_next;
    logic [2:0]             word_reg, word_next;
    logic                   line_open_reg, line_open_next;
    logic                   chunked_reg, chunked_next;
    logic [SIZE_BITS-1:0]   count_reg, count_next;
    logic                   cr_reg, cr_next;
    logic [1:0]             skip_reg, skip_next;
    logic                   keep;
    logic [7:0]             lc;
    logic                   line_end;
    logic [4:0]             hex;
    logic [SIZE_BITS-1:0]   count_dec;
    logic [1:0]             skip_inc;

    function automatic logic [7:0] to_lower(logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= "A" && b <= "Z")
        begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [4:0] name_step(logic [4:0] k, logic [7:0] c);
        logic [4:0] r;
        r = (c == NAME_TEXT[0]) ? 5'd1 : 5'd0;
        if (k < NAME_END)
        begin
            if (c == NAME_TEXT[k])
            begin
                r = k + 5'd1;
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] word_step(logic [2:0] k, logic [7:0] c);
        logic [2:0] r;
        r = (c == WORD_TEXT[0]) ? 3'd1 : 3'd0;
        if (k < WORD_END)
        begin
            if (c == WORD_TEXT[k])
            begin
                r = k + 3'd1;
            end
        end
        return r;
    endfunction

    // msb flags a hex digit, low four bits its value
    function automatic logic [4:0] hex_value(logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9")
        begin
            r = {1'b1, 4'(b - "0")};
        end
        else if (b >= "a" && b <= "f")
        begin
            r = {1'b1, 4'(b - "a" + 8'd10)};
        end
        else if (b >= "A" && b <= "F")
        begin
            r = {1'b1, 4'(b - "A" + 8'd10)};
        end
        return r;
    endfunction

    assign lc        = to_lower(in_byte);
    assign line_end  = (in_byte == CHAR_LF) && (blank_reg == 2'd1 || blank_reg == 2'd3);
    assign hex       = hex_value(in_byte);
    assign count_dec = count_reg - SIZE_BITS'(1);
    assign skip_inc  = skip_reg + 2'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        blank_next     = blank_reg;
        name_next      = name_reg;
        word_next      = word_reg;
        line_open_next = line_open_reg;
        chunked_next   = chunked_reg;
        count_next     = count_reg;
        cr_next        = cr_reg;
        skip_next      = skip_reg;
        keep           = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                keep = 1'b1;
                // encoding header search
                if (line_open_reg)
                begin
                    if (line_end)
                    begin
                        line_open_next = 1'b0;
                    end
                    else
                    begin
                        word_next = word_step(word_reg, lc);
                        if (word_next == WORD_END)
                        begin
                            chunked_next   = 1'b1;
                            line_open_next = 1'b0;
                            word_next      = 3'd0;
                        end
                    end
                end
                else if (name_reg < NAME_END)
                begin
                    name_next = name_step(name_reg, lc);
                    if (name_next == NAME_END)
                    begin
                        line_open_next = 1'b1;
                        word_next      = 3'd0;
                    end
                end

                // blank line search
                if (in_byte == CHAR_CR)
                begin
                    blank_next = (blank_reg == 2'd2) ? 2'd3 : 2'd1;
                end
                else if (in_byte == CHAR_LF && blank_reg == 2'd1)
                begin
                    blank_next = 2'd2;
                end
                else if (in_byte == CHAR_LF && blank_reg == 2'd3)
                begin
                    blank_next     = 2'd0;
                    line_open_next = 1'b0;
                    phase_next     = chunked_next ? PH_DIGITS : PH_PASS;
                    count_next     = '0;
                end
                else
                begin
                    blank_next = 2'd0;
                end
            end
            PH_PASS:
            begin
                keep = 1'b1;
            end
            PH_DIGITS:
            begin
                if (hex[4])
                begin
                    if (count_reg[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        count_next = COUNT_MAX;
                    end
                    else
                    begin
                        count_next = {count_reg[SIZE_BITS-5:0], hex[3:0]};
                    end
                end
                else if (count_reg == '0)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    cr_next    = (in_byte == CHAR_CR);
                    phase_next = PH_SIZE_SKIP;
                end
            end
            PH_SIZE_SKIP:
            begin
                if (cr_reg && in_byte == CHAR_LF)
                begin
                    cr_next    = 1'b0;
                    phase_next = PH_DATA;
                end
                else
                begin
                    cr_next = (in_byte == CHAR_CR);
                end
            end
            PH_DATA:
            begin
                keep       = 1'b1;
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    skip_next  = 2'd0;
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                skip_next = skip_inc;
                if (skip_inc >= 2'd2)
                begin
                    skip_next  = 2'd0;
                    count_next = '0;
                    phase_next = PH_DIGITS;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    assign result = '{data: in_byte, keep: keep, last: in_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            blank_reg     <= 2'd0;
            name_reg      <= 5'd0;
            word_reg      <= 3'd0;
            line_open_reg <= 1'b0;
            chunked_reg   <= 1'b0;
            count_reg     <= '0;
            cr_reg        <= 1'b0;
            skip_reg      <= 2'd0;
        end
        else if (step)
        begin
            // last item of a response starts the next one from scratch
            if (in_last)
            begin
                phase_reg     <= PH_HEADER;
                blank_reg     <= 2'd0;
                name_reg      <= 5'd0;
                word_reg      <= 3'd0;
                line_open_reg <= 1'b0;
                chunked_reg   <= 1'b0;
                count_reg     <= '0;
                cr_reg        <= 1'b0;
                skip_reg      <= 2'd0;
            end
            else
            begin
                phase_reg     <= phase_next;
                blank_reg     <= blank_next;
                name_reg      <= name_next;
                word_reg      <= word_next;
                line_open_reg <= line_open_next;
                chunked_reg   <= chunked_next;
                count_reg     <= count_next;
                cr_reg        <= cr_next;
                skip_reg      <= skip_next;
            end
        end
    end

endmodule

[design/hcbd_out_reg.sv]
module hcbd_out_reg
    import hcbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output logic [7:0] out_byte,
    output logic    keep,
    output logic    out_last
);

    logic    valid_reg;
    result_t data_reg;

    assign room = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = data_reg.data;
    assign keep      = data_reg.keep;
    assign out_last  = data_reg.last;

endmodule

[design/hcbd_checker.sv]
module hcbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       keep,
    input logic       out_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(keep) && $stable(out_last))
        else $error("result changed while stalled");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item did not produce a result");

    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_byte == $past(in_byte)
            && out_last == $past(in_last))
        else $error("result does not echo the item");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item accepted over a held result");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .keep      (keep),
    .out_last  (out_last)
);
